// File: hdl/pff_pkg.sv
// ----------------------------------------------------------------------------
// pff_pkg: shared definitions for the printf field formatter
// Conversion codes, character constants, converter sizes and digit mapping.
// ----------------------------------------------------------------------------
package pff_pkg;

	localparam int WORD_BITS  = 32;
	localparam int MAX_WIDTH  = 64;
	localparam int FW_BITS    = 7;
	// Ten BCD digits hold any 32-bit value; eight hex digits fit in the same space.
	localparam int BCD_DIGITS = 10;
	localparam int BCD_BITS   = 4 * BCD_DIGITS;
	localparam int CNT_W      = $clog2(WORD_BITS);
	localparam int ND_W       = $clog2(BCD_DIGITS + 2);

	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_HEXL = 3'd2;
	localparam logic [2:0] OP_HEXU = 3'd3;
	localparam logic [2:0] OP_CHAR = 3'd4;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UP_A : CH_LOW_A;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'd0, d};
		else
			digit_char = base + {4'd0, d - 4'd10};
	endfunction

endpackage

// File: hdl/printf_field_formatter.sv
// ----------------------------------------------------------------------------
// printf_field_formatter: one integer or character conversion to ASCII text
// Formats a decoded conversion into a padded field, one character per word.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) takes one conversion word: opcode,
// value, field_width, left_justify and zero_pad. The output channel
// (out_valid/out_stall) returns the field one character per word, with last
// set on the final character. Opcodes 5 to 7 are taken and produce nothing.
// Decimal values go through a bit-serial binary to BCD converter, one bit per
// cycle, then a leading-zero scan that drops up to nine leading zero digits,
// one per cycle. Hex values skip the converter, characters skip both. Once
// the field is laid out, one character leaves per cycle while the receiver
// does not stall. The next conversion can be taken in the cycle after the
// last character has entered the output register. When the receiver stalls,
// the output register holds its word and the generator waits. Reset empties
// the output register and returns the block to idle.
// ----------------------------------------------------------------------------
module printf_field_formatter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [31:0]                   value,
	input  logic [pff_pkg::FW_BITS-1:0]   field_width,
	input  logic                          left_justify,
	input  logic                          zero_pad,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_char,
	output logic                          last
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DABBLE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_PREP   = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	localparam int WB = pff_pkg::WORD_BITS;
	localparam int BB = pff_pkg::BCD_BITS;
	localparam int FW = pff_pkg::FW_BITS;
	localparam int NW = pff_pkg::ND_W;

	state_t                        state_q;
	logic                          out_valid_q;
	logic [7:0]                    out_char_q;
	logic                          last_q;

	logic                          is_char_q, upper_q, neg_q, zpad_q, ljust_q;
	logic [FW-1:0]                 width_q;
	logic [WB-1:0]                 bin_q;
	logic [BB-1:0]                 bcd_q;
	logic [pff_pkg::CNT_W-1:0]     cnt_q;
	logic [NW-1:0]                 nd_q;
	logic                          sf_q, tsign_q, chp_q;
	logic [FW-1:0]                 lpad_q, rpad_q, tot_q;

	logic [WB-1:0]                 in_word, in_mag;
	logic                          in_neg;
	logic [FW-1:0]                 in_width;
	logic [BB-1:0]                 bcd_adj;
	logic                          slot_free, emit;
	logic [7:0]                    emit_char;
	logic                          p_sf, p_ts, p_chp;
	logic [FW-1:0]                 p_len, p_w, p_pad;
	logic [3:0]                    top_digit;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	assign in_word  = value[WB-1:0];
	assign in_neg   = (opcode == pff_pkg::OP_SDEC) && in_word[WB-1];
	assign in_mag   = in_neg ? (~in_word + 1'b1) : in_word;
	assign in_width = (field_width > FW'(pff_pkg::MAX_WIDTH)) ?
		FW'(pff_pkg::MAX_WIDTH) : field_width;

	// Double-dabble correction: every digit of five or more gets three added
	// before the shift.
	always_comb begin
		for (int k = 0; k < pff_pkg::BCD_DIGITS; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ?
				bcd_q[4*k +: 4] + 4'd3 : bcd_q[4*k +: 4];
		end
	end

	assign top_digit = bcd_q[BB-1 -: 4];

	// Field layout, worked out once the digit count is known.
	always_comb begin
		p_sf  = neg_q && (width_q != '0) && zpad_q;
		p_ts  = neg_q && !p_sf;
		p_chp = is_char_q && ((width_q == '0) || (bin_q[7:0] != 8'd0));
		p_len = is_char_q ? FW'(p_chp) : (FW'(nd_q) + FW'(p_ts));
		p_w   = width_q - FW'(p_sf);
		p_pad = (p_w > p_len) ? (p_w - p_len) : '0;
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = (state_q == S_EMIT) && slot_free;

	always_comb begin
		priority if (sf_q)
			emit_char = pff_pkg::CH_MINUS;
		else if (lpad_q != '0)
			emit_char = zpad_q ? pff_pkg::CH_ZERO : pff_pkg::CH_SPACE;
		else if (tsign_q)
			emit_char = pff_pkg::CH_MINUS;
		else if (chp_q)
			emit_char = bin_q[7:0];
		else if (nd_q != '0)
			emit_char = pff_pkg::digit_char(top_digit, upper_q);
		else
			emit_char = zpad_q ? pff_pkg::CH_ZERO : pff_pkg::CH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						priority case (opcode)
							pff_pkg::OP_SDEC, pff_pkg::OP_UDEC: state_q <= S_DABBLE;
							pff_pkg::OP_HEXL, pff_pkg::OP_HEXU: state_q <= S_SCAN;
							pff_pkg::OP_CHAR:                   state_q <= S_PREP;
							default:                            state_q <= S_IDLE;
						endcase
					end
				end
				S_DABBLE: begin
					if (cnt_q == pff_pkg::CNT_W'(WB - 1))
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!((nd_q > NW'(1)) && (top_digit == 4'd0)))
						state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit && (tot_q == FW'(1)))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_char;
			last_q     <= (tot_q == FW'(1));
		end

		unique case (state_q)
			S_IDLE: begin
				is_char_q <= (opcode == pff_pkg::OP_CHAR);
				upper_q   <= (opcode == pff_pkg::OP_HEXU);
				neg_q     <= in_neg;
				zpad_q    <= zero_pad;
				ljust_q   <= left_justify;
				width_q   <= in_width;
				bin_q     <= in_mag;
				bcd_q     <= ((opcode == pff_pkg::OP_SDEC) || (opcode == pff_pkg::OP_UDEC)) ?
					'0 : BB'(in_mag);
				cnt_q     <= '0;
				nd_q      <= NW'(pff_pkg::BCD_DIGITS);
			end
			S_DABBLE: begin
				bcd_q <= {bcd_adj[BB-2:0], bin_q[WB-1]};
				bin_q <= bin_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			S_SCAN: begin
				if ((nd_q > NW'(1)) && (top_digit == 4'd0)) begin
					bcd_q <= bcd_q << 4;
					nd_q  <= nd_q - 1'b1;
				end
			end
			S_PREP: begin
				sf_q    <= p_sf;
				tsign_q <= p_ts;
				chp_q   <= p_chp;
				if (is_char_q)
					nd_q <= '0;
				lpad_q  <= ljust_q ? '0 : p_pad;
				rpad_q  <= ljust_q ? p_pad : '0;
				tot_q   <= FW'(p_sf) + p_pad + p_len;
			end
			S_EMIT: begin
				if (emit) begin
					tot_q <= tot_q - 1'b1;
					priority if (sf_q)
						sf_q <= 1'b0;
					else if (lpad_q != '0)
						lpad_q <= lpad_q - 1'b1;
					else if (tsign_q)
						tsign_q <= 1'b0;
					else if (chp_q)
						chp_q <= 1'b0;
					else if (nd_q != '0) begin
						bcd_q <= bcd_q << 4;
						nd_q  <= nd_q - 1'b1;
					end else
						rpad_q <= rpad_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// A valid conversion always leaves idle on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (opcode <= pff_pkg::OP_CHAR)) |=> (state_q != S_IDLE))
		else $error("valid conversion did not start");

	// While characters are generated there is always at least one left.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (tot_q != '0))
		else $error("emit state with nothing to send");

	// The final character returns the block to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (tot_q == FW'(1))) |=> (state_q == S_IDLE) && out_valid && last)
		else $error("last character did not end the conversion");

	// The digit scan never drops the final digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (nd_q != '0))
		else $error("digit scan lost all digits");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for printf_field_formatter
// Sends decoded conversions with bursty timing, predicts the padded ASCII
// field of each one and checks every output word in order against it.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          TAIL_CYCLES = 120;
	localparam int          RANDOM_CONVS = 460;
	localparam logic [2:0]  OP_TOP = 3'd7;

	typedef struct {
		logic [2:0]                  op;
		logic [31:0]                 val;
		logic [pff_pkg::FW_BITS-1:0] fw;
		logic                        lj;
		logic                        zp;
	} conv_t;

	class field_text_tracker;
		logic [7:0] want_char[$];
		logic       want_last[$];
		int         bad_count;

		function new();
			bad_count = 0;
		endfunction

		function int pending();
			return want_char.size();
		endfunction

		// Builds the expected field of one accepted conversion.
		function void note_conversion(conv_t c);
			logic [7:0]  body[$];
			logic [7:0]  digits[$];
			logic [7:0]  field[$];
			logic [7:0]  pad_ch;
			logic [7:0]  d;
			logic [7:0]  alpha;
			logic [31:0] mag;
			logic [31:0] radix;
			int          cols;
			bit          negative;
			cols = (c.fw > pff_pkg::MAX_WIDTH) ? pff_pkg::MAX_WIDTH : int'(c.fw);
			if (c.op > pff_pkg::OP_CHAR)
				return;
			if (c.op == pff_pkg::OP_CHAR) begin
				if (cols == 0) begin
					want_char.push_back(c.val[7:0]);
					want_last.push_back(1'b1);
					return;
				end
				// With a width the character acts as a string, so NUL prints nothing.
				if (c.val[7:0] != 8'd0)
					body.push_back(c.val[7:0]);
			end else if (c.val == 32'd0) begin
				body.push_back(pff_pkg::CH_ZERO);
			end else begin
				radix = (c.op == pff_pkg::OP_HEXL || c.op == pff_pkg::OP_HEXU) ?
					32'd16 : 32'd10;
				alpha = (c.op == pff_pkg::OP_HEXU) ? pff_pkg::CH_UP_A : pff_pkg::CH_LOW_A;
				negative = (c.op == pff_pkg::OP_SDEC) && c.val[31];
				mag = negative ? 32'd0 - c.val : c.val;
				while (mag != 32'd0) begin
					d = 8'(mag % radix);
					digits.push_front((d < 8'd10) ? pff_pkg::CH_ZERO + d
						: alpha + d - 8'd10);
					mag = mag / radix;
				end
				// A zero-padded negative field puts its sign ahead of the padding.
				if (negative) begin
					if (cols != 0 && c.zp) begin
						field.push_back(pff_pkg::CH_MINUS);
						cols--;
					end else begin
						body.push_back(pff_pkg::CH_MINUS);
					end
				end
				foreach (digits[i])
					body.push_back(digits[i]);
			end
			pad_ch = pff_pkg::CH_SPACE;
			if (cols > 0) begin
				cols = (body.size() >= cols) ? 0 : cols - body.size();
				if (c.zp)
					pad_ch = pff_pkg::CH_ZERO;
			end
			if (!c.lj)
				repeat (cols) field.push_back(pad_ch);
			foreach (body[i])
				field.push_back(body[i]);
			if (c.lj)
				repeat (cols) field.push_back(pad_ch);
			foreach (field[i]) begin
				want_char.push_back(field[i]);
				want_last.push_back(i == field.size() - 1);
			end
		endfunction

		function void check_char(logic [7:0] got_char, logic got_last);
			logic [7:0] exp_char;
			logic       exp_last;
			if (want_char.size() == 0) begin
				$display("%0t ns: unexpected word, out_char 8'h%02h last %0b, expected none",
					$time, got_char, got_last);
				bad_count++;
				return;
			end
			exp_char = want_char.pop_front();
			exp_last = want_last.pop_front();
			if (got_char !== exp_char) begin
				$display("%0t ns: out_char expected 8'h%02h, actual 8'h%02h",
					$time, exp_char, got_char);
				bad_count++;
			end
			if (got_last !== exp_last) begin
				$display("%0t ns: last expected %0b, actual %0b", $time, exp_last, got_last);
				bad_count++;
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [2:0]                  opcode = pff_pkg::OP_SDEC;
	logic [31:0]                 value = 32'd0;
	logic [pff_pkg::FW_BITS-1:0] field_width = '0;
	logic                        left_justify = 1'b0;
	logic                        zero_pad = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [7:0]                  out_char;
	logic                        last;

	field_text_tracker  book;
	int                 cycle_count = 0;
	int                 stall_mode = 0;
	int                 mode_left = 0;

	printf_field_formatter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.value        (value),
		.field_width  (field_width),
		.left_justify (left_justify),
		.zero_pad     (zero_pad),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last         (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Receiver: checks each accepted word and switches between stall patterns.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_char(out_char, last);
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(20, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 7) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_stall <= ~out_stall;
			end
		endcase
	end

	function automatic conv_t conv(logic [2:0] op, logic [31:0] val, int fw, bit lj, bit zp);
		conv_t c;
		c.op = op;
		c.val = val;
		c.fw = pff_pkg::FW_BITS'(fw);
		c.lj = lj;
		c.zp = zp;
		return c;
	endfunction

	function automatic conv_t random_conv();
		conv_t c;
		int    pick;
		pick = $urandom_range(0, 99);
		c.op = (pick < 90) ? 3'($urandom_range(pff_pkg::OP_SDEC, pff_pkg::OP_CHAR))
			: 3'($urandom_range(pff_pkg::OP_CHAR + 1, OP_TOP));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c.val = $urandom;
		else if (pick < 60)
			c.val = $urandom_range(0, 999);
		else if (pick < 75)
			c.val = 32'd0 - 32'($urandom_range(1, 999));
		else if (pick < 85)
			c.val = $urandom & 32'hFFFF_FF00;
		else begin
			case ($urandom_range(0, 4))
				0: c.val = 32'd0;
				1: c.val = 32'd1;
				2: c.val = 32'h7FFF_FFFF;
				3: c.val = 32'h8000_0000;
				default: c.val = 32'hFFFF_FFFF;
			endcase
		end
		pick = $urandom_range(0, 99);
		if (pick < 50)
			c.fw = pff_pkg::FW_BITS'($urandom_range(0, 12));
		else if (pick < 80)
			c.fw = pff_pkg::FW_BITS'($urandom_range(0, pff_pkg::MAX_WIDTH));
		else if (pick < 90)
			c.fw = pff_pkg::FW_BITS'($urandom_range(pff_pkg::MAX_WIDTH + 1,
				(1 << pff_pkg::FW_BITS) - 1));
		else
			c.fw = '0;
		c.lj = 1'($urandom_range(0, 1));
		c.zp = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Holds the word steady until the block takes it.
	task automatic send_conv(input conv_t c);
		in_valid     <= 1'b1;
		opcode       <= c.op;
		value        <= c.val;
		field_width  <= c.fw;
		left_justify <= c.lj;
		zero_pad     <= c.zp;
		do @(posedge clk); while (in_stall);
		book.note_conversion(c);
	endtask

	task automatic wait_drained();
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		conv_t plan[$];
		int    burst_left;
		int    drain_at;
		book = new();

		plan.push_back(conv(pff_pkg::OP_SDEC, 32'd0, 0, 0, 0));
		plan.push_back(conv(pff_pkg::OP_SDEC, 32'h8000_0000, 0, 0, 0));
		plan.push_back(conv(pff_pkg::OP_SDEC, 32'h8000_0000, 12, 0, 1));
		plan.push_back(conv(pff_pkg::OP_SDEC, 32'hFFFF_FFFF, 8, 0, 1));
		plan.push_back(conv(pff_pkg::OP_SDEC, 32'd0 - 32'd1234, 8, 0, 0));
		plan.push_back(conv(pff_pkg::OP_SDEC, 32'd0 - 32'd1234, 8, 1, 1));
		plan.push_back(conv(pff_pkg::OP_SDEC, 32'd0 - 32'd5, 1, 0, 1));
		plan.push_back(conv(pff_pkg::OP_SDEC, 32'h7FFF_FFFF, 127, 0, 0));
		plan.push_back(conv(pff_pkg::OP_UDEC, 32'hFFFF_FFFF, 3, 0, 0));
		plan.push_back(conv(pff_pkg::OP_UDEC, 32'd42, pff_pkg::MAX_WIDTH, 1, 1));
		plan.push_back(conv(pff_pkg::OP_UDEC, 32'h8000_0000, pff_pkg::MAX_WIDTH + 1, 1, 1));
		plan.push_back(conv(pff_pkg::OP_HEXL, 32'hDEAD_BEEF, 0, 0, 0));
		plan.push_back(conv(pff_pkg::OP_HEXU, 32'hDEAD_BEEF, 12, 0, 1));
		plan.push_back(conv(pff_pkg::OP_HEXU, 32'd0, 5, 1, 0));
		plan.push_back(conv(pff_pkg::OP_HEXL, 32'hABCD_EF01, 127, 1, 1));
		plan.push_back(conv(pff_pkg::OP_CHAR, 32'h0000_0041, 0, 0, 0));
		plan.push_back(conv(pff_pkg::OP_CHAR, 32'hFFFF_FF00, 0, 0, 0));
		plan.push_back(conv(pff_pkg::OP_CHAR, 32'h0000_0000, 5, 0, 1));
		plan.push_back(conv(pff_pkg::OP_CHAR, 32'h0000_00FF, pff_pkg::MAX_WIDTH, 1, 1));
		plan.push_back(conv(pff_pkg::OP_CHAR, 32'h0000_007A, 1, 0, 0));
		plan.push_back(conv(pff_pkg::OP_CHAR + 3'd1, 32'hFFFF_FFFF, 10, 1, 1));
		plan.push_back(conv(pff_pkg::OP_CHAR + 3'd2, 32'd7, 0, 0, 0));
		plan.push_back(conv(OP_TOP, 32'd0, 127, 0, 0));
		plan.push_back(conv(pff_pkg::OP_UDEC, 32'd7, 4, 0, 0));
		drain_at = plan.size() + RANDOM_CONVS / 2;
		repeat (RANDOM_CONVS) plan.push_back(random_conv());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = $urandom_range(1, 12);
		foreach (plan[i]) begin
			if (i == drain_at) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			send_conv(plan[i]);
			burst_left--;
			if (burst_left == 0) begin
				// Some bursts are long and leave the sender busy for a while.
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 12);
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.bad_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
